### rtl/lrp_pkg.sv
// lrp_pkg: shared codes for the table-driven LR parse engine
// item operation codes, result kinds, error causes and parse status codes
// no dependencies
package lrp_pkg;

    // item operation codes
    localparam logic [1:0] OP_WRITE_CELL = 2'd0;
    localparam logic [1:0] OP_WRITE_RULE = 2'd1;
    localparam logic [1:0] OP_TOKEN      = 2'd2;
    localparam logic [1:0] OP_RESTART    = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_REDUCE  = 3'd0;
    localparam logic [2:0] KIND_SHIFT   = 3'd1;
    localparam logic [2:0] KIND_ACCEPT  = 3'd2;
    localparam logic [2:0] KIND_ERROR   = 3'd3;
    localparam logic [2:0] KIND_IGNORED = 3'd4;

    // error causes
    localparam logic [2:0] CAUSE_NONE         = 3'd0;
    localparam logic [2:0] CAUSE_EMPTY_CELL   = 3'd1;
    localparam logic [2:0] CAUSE_OVERFLOW     = 3'd2;
    localparam logic [2:0] CAUSE_UNDERFLOW    = 3'd3;
    localparam logic [2:0] CAUSE_BAD_GOTO     = 3'd4;
    localparam logic [2:0] CAUSE_REDUCE_LIMIT = 3'd5;

    // parse status
    localparam logic [1:0] STATUS_RUN = 2'd0;
    localparam logic [1:0] STATUS_ACC = 2'd1;
    localparam logic [1:0] STATUS_ERR = 2'd2;

endpackage

### rtl/lr_parse_driver.sv
// lr_parse_driver: table-driven LR shift-reduce parse engine
// action table, rule table and state stack in synchronous memories, one sequencer
// depends on lrp_pkg
//
// Usage: one input channel (item_valid/item_stall) carries cell writes, rule
// writes, tokens and restarts; one output channel (result_valid/result_stall)
// carries one beat per reduction and a final shift, accept, error or ignored
// beat marked by last. Cell writes, rule writes and restarts give no beat. A
// token's action cell is read when the token is accepted; each reduction then
// steps through action read, rule read, stack read and goto read, and no
// further item is accepted before the token's final beat. A token after accept
// or error gives its ignored beat at once. After reset the action table, all
// 2**(clog2(STATES)+clog2(SYMBOLS)) cells (1024 by default), is swept to empty,
// one cell per cycle; item_stall stays high during the sweep. The rule table is
// not cleared and a rule must be written before a reduction uses it. While
// result_stall holds a beat, the engine waits with the next beat and stalls
// further items. No memory is read in the same cycle as it is written, so no
// forwarding is needed.
module lr_parse_driver
    import lrp_pkg::*;
#(
    parameter int STATES         = 64,
    parameter int SYMBOLS        = 16,
    parameter int RULES          = 32,
    parameter int STACK_DEPTH    = 32,
    parameter int MAX_REDUCTIONS = 63
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [1:0]        op,
    input  logic [5:0]        state_row,
    input  logic [3:0]        symbol_column,
    input  logic signed [6:0] action_value,
    input  logic [4:0]        rule_index,
    input  logic [3:0]        rule_symbol,
    input  logic [3:0]        rule_length,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [2:0]        kind,
    output logic [4:0]        rule_number,
    output logic [5:0]        new_state,
    output logic [2:0]        error_cause,
    output logic              last
);

    localparam int RW     = $clog2(STATES);
    localparam int CW     = $clog2(SYMBOLS);
    localparam int AW     = RW + CW;
    localparam int ADEPTH = 1 << AW;
    localparam int RIW    = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int SIW    = $clog2(STACK_DEPTH);
    localparam int SPW    = $clog2(STACK_DEPTH + 1);

    // sequencer codes
    localparam logic [2:0] SEQ_IDLE = 3'd0;
    localparam logic [2:0] SEQ_ACT  = 3'd1;
    localparam logic [2:0] SEQ_RULE = 3'd2;
    localparam logic [2:0] SEQ_BASE = 3'd3;
    localparam logic [2:0] SEQ_GOTO = 3'd4;

    // memories
    logic signed [6:0] act_mem [ADEPTH];
    logic [7:0]        rule_mem [RULES];
    logic [RW-1:0]     stk_mem [STACK_DEPTH];

    logic signed [6:0] act_q;
    logic [7:0]        rule_q;
    logic [RW-1:0]     stk_q;

    // control state
    logic [2:0]     seq_reg, seq_next;
    logic           clr_busy_reg;
    logic [AW-1:0]  clr_cnt_reg;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [RW-1:0]  top_reg, top_next;
    logic [1:0]     status_reg, status_next;
    logic [5:0]     reds_reg, reds_next;
    logic [CW-1:0]  col_reg, col_next;
    logic           col_bad_reg, col_bad_next;
    logic [5:0]     rule_reg, rule_next;
    logic           base_zero_reg, base_zero_next;
    logic           sym_bad_reg, sym_bad_next;

    // output beat
    logic       res_valid_reg;
    logic [2:0] kind_reg, kind_next;
    logic [4:0] rule_num_reg, rule_num_next;
    logic [5:0] new_state_reg, new_state_next;
    logic [2:0] cause_reg, cause_next;
    logic       last_reg, last_next;
    logic       out_load;
    logic       out_free;

    // memory port controls
    logic              act_we, act_re;
    logic [AW-1:0]     act_waddr, act_raddr;
    logic signed [6:0] act_wdata;
    logic              rule_we, rule_re;
    logic [RIW-1:0]    rule_waddr, rule_raddr;
    logic              stk_we, stk_re;
    logic [SIW-1:0]    stk_waddr, stk_raddr;
    logic [RW-1:0]     stk_wdata;

    // input field decode
    logic [8:0] row_ext;
    logic [6:0] col_ext;
    logic [7:0] ri_ext;
    logic       row_ok, col_ok, ri_ok;
    logic       item_fire;

    // datapath terms
    logic signed [6:0] a_eff;
    logic [6:0]        a_inv;
    logic [5:0]        red_rule;
    logic [7:0]        red_rule_ext;
    logic [3:0]        rl_sym, rl_len;
    logic [SPW-1:0]    base_idx, push_base;
    logic [RW-1:0]     base_state;
    logic [6:0]        sym_ext;
    logic signed [6:0] gv;
    logic [7:0]        gv_ext, av_ext, top_ext;

    assign row_ext   = 9'(state_row);
    assign col_ext   = 7'(symbol_column);
    assign ri_ext    = 8'(rule_index);
    assign row_ok    = row_ext < 9'(STATES);
    assign col_ok    = col_ext < 7'(SYMBOLS);
    assign ri_ok     = ri_ext < 8'(RULES);
    assign out_free  = !res_valid_reg || !result_stall;
    assign item_stall = clr_busy_reg || (seq_reg != SEQ_IDLE) || !out_free;
    assign item_fire = item_valid && !item_stall;

    assign a_eff        = col_bad_reg ? 7'sd0 : act_q;
    assign a_inv        = ~a_eff;
    assign red_rule     = a_inv[5:0] - 6'd1;
    assign red_rule_ext = 8'(red_rule);
    assign av_ext       = 8'(a_eff[5:0]);
    assign rl_sym       = rule_q[7:4];
    assign rl_len       = rule_q[3:0];
    assign base_idx     = sp_reg - SPW'(rl_len) - SPW'(1);
    assign push_base    = sp_reg - SPW'(rl_len);
    assign base_state   = base_zero_reg ? RW'(0) : stk_q;
    assign sym_ext      = 7'(rl_sym);
    assign gv           = sym_bad_reg ? 7'sd0 : act_q;
    assign gv_ext       = 8'(gv[5:0]);
    assign top_ext      = 8'(top_reg);

    // sequencer and datapath
    always_comb
    begin
        seq_next       = seq_reg;
        sp_next        = sp_reg;
        top_next       = top_reg;
        status_next    = status_reg;
        reds_next      = reds_reg;
        col_next       = col_reg;
        col_bad_next   = col_bad_reg;
        rule_next      = rule_reg;
        base_zero_next = base_zero_reg;
        sym_bad_next   = sym_bad_reg;

        out_load       = 1'b0;
        kind_next      = KIND_ERROR;
        rule_num_next  = 5'd0;
        new_state_next = top_ext[5:0];
        cause_next     = CAUSE_NONE;
        last_next      = 1'b1;

        act_we     = clr_busy_reg;
        act_waddr  = clr_cnt_reg;
        act_wdata  = 7'sd0;
        act_re     = 1'b0;
        act_raddr  = {top_reg, col_ext[CW-1:0]};
        rule_we    = 1'b0;
        rule_waddr = ri_ext[RIW-1:0];
        rule_re    = 1'b0;
        rule_raddr = red_rule_ext[RIW-1:0];
        stk_we     = 1'b0;
        stk_waddr  = push_base[SIW-1:0];
        stk_wdata  = gv_ext[RW-1:0];
        stk_re     = 1'b0;
        stk_raddr  = base_idx[SIW-1:0];

        unique case (seq_reg)
            SEQ_IDLE:
            begin
                if (item_fire)
                begin
                    unique case (op)
                        OP_WRITE_CELL:
                        begin
                            act_we    = row_ok && col_ok;
                            act_waddr = {row_ext[RW-1:0], col_ext[CW-1:0]};
                            act_wdata = action_value;
                        end
                        OP_WRITE_RULE:
                        begin
                            rule_we = ri_ok;
                        end
                        OP_TOKEN:
                        begin
                            if (status_reg != STATUS_RUN)
                            begin
                                out_load  = 1'b1;
                                kind_next = KIND_IGNORED;
                            end
                            else
                            begin
                                act_re       = 1'b1;
                                reds_next    = 6'd0;
                                col_next     = col_ext[CW-1:0];
                                col_bad_next = !col_ok;
                                seq_next     = SEQ_ACT;
                            end
                        end
                        OP_RESTART:
                        begin
                            sp_next     = SPW'(1);
                            top_next    = RW'(0);
                            status_next = STATUS_RUN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            SEQ_ACT:
            begin
                // decode the action cell for the current top state
                if (out_free)
                begin
                    if (a_eff == 7'sd0)
                    begin
                        out_load    = 1'b1;
                        cause_next  = CAUSE_EMPTY_CELL;
                        status_next = STATUS_ERR;
                        seq_next    = SEQ_IDLE;
                    end
                    else if (a_eff == -7'sd1)
                    begin
                        out_load    = 1'b1;
                        kind_next   = KIND_ACCEPT;
                        status_next = STATUS_ACC;
                        seq_next    = SEQ_IDLE;
                    end
                    else if (!a_eff[6])
                    begin
                        // shift
                        out_load = 1'b1;
                        seq_next = SEQ_IDLE;
                        if (9'(av_ext) >= 9'(STATES))
                        begin
                            cause_next  = CAUSE_BAD_GOTO;
                            status_next = STATUS_ERR;
                        end
                        else if (9'(sp_reg) >= 9'(STACK_DEPTH))
                        begin
                            cause_next  = CAUSE_OVERFLOW;
                            status_next = STATUS_ERR;
                        end
                        else
                        begin
                            kind_next      = KIND_SHIFT;
                            new_state_next = av_ext[5:0];
                            stk_we         = 1'b1;
                            stk_waddr      = sp_reg[SIW-1:0];
                            stk_wdata      = av_ext[RW-1:0];
                            sp_next        = sp_reg + SPW'(1);
                            top_next       = av_ext[RW-1:0];
                        end
                    end
                    else
                    begin
                        // reduce: check limits, then fetch the rule
                        rule_next = red_rule;
                        if (7'(reds_reg) >= 7'(MAX_REDUCTIONS))
                        begin
                            out_load      = 1'b1;
                            rule_num_next = red_rule[4:0];
                            cause_next    = CAUSE_REDUCE_LIMIT;
                            status_next   = STATUS_ERR;
                            seq_next      = SEQ_IDLE;
                        end
                        else if (red_rule_ext >= 8'(RULES))
                        begin
                            out_load      = 1'b1;
                            rule_num_next = red_rule[4:0];
                            cause_next    = CAUSE_EMPTY_CELL;
                            status_next   = STATUS_ERR;
                            seq_next      = SEQ_IDLE;
                        end
                        else
                        begin
                            rule_re  = 1'b1;
                            seq_next = SEQ_RULE;
                        end
                    end
                end
            end

            SEQ_RULE:
            begin
                // check stack depth, fetch the base state under the popped entries
                if (out_free)
                begin
                    if (9'(rl_len) >= 9'(sp_reg))
                    begin
                        out_load      = 1'b1;
                        rule_num_next = rule_reg[4:0];
                        cause_next    = CAUSE_UNDERFLOW;
                        status_next   = STATUS_ERR;
                        seq_next      = SEQ_IDLE;
                    end
                    else
                    begin
                        stk_re         = 1'b1;
                        base_zero_next = (base_idx == SPW'(0));
                        seq_next       = SEQ_BASE;
                    end
                end
            end

            SEQ_BASE:
            begin
                // goto lookup for the rule's left-hand symbol
                act_re       = 1'b1;
                act_raddr    = {base_state, sym_ext[CW-1:0]};
                sym_bad_next = sym_ext >= 7'(SYMBOLS);
                seq_next     = SEQ_GOTO;
            end

            SEQ_GOTO:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    rule_num_next = rule_reg[4:0];
                    if (gv[6] || (gv == 7'sd0) || (9'(gv_ext) >= 9'(STATES)))
                    begin
                        cause_next  = CAUSE_BAD_GOTO;
                        status_next = STATUS_ERR;
                        seq_next    = SEQ_IDLE;
                    end
                    else if (9'(push_base) >= 9'(STACK_DEPTH))
                    begin
                        cause_next  = CAUSE_OVERFLOW;
                        status_next = STATUS_ERR;
                        seq_next    = SEQ_IDLE;
                    end
                    else
                    begin
                        // pop, push goto state, look up the token again
                        kind_next      = KIND_REDUCE;
                        new_state_next = gv_ext[5:0];
                        last_next      = 1'b0;
                        stk_we         = 1'b1;
                        sp_next        = push_base + SPW'(1);
                        top_next       = gv_ext[RW-1:0];
                        reds_next      = reds_reg + 6'd1;
                        act_re         = 1'b1;
                        act_raddr      = {gv_ext[RW-1:0], col_reg};
                        seq_next       = SEQ_ACT;
                    end
                end
            end

            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    // action table memory
    always_ff @(posedge clk)
    begin
        if (act_we)
        begin
            act_mem[act_waddr] <= act_wdata;
        end
        if (act_re)
        begin
            act_q <= act_mem[act_raddr];
        end
    end

    // rule table memory
    always_ff @(posedge clk)
    begin
        if (rule_we)
        begin
            rule_mem[rule_waddr] <= {rule_symbol, rule_length};
        end
        if (rule_re)
        begin
            rule_q <= rule_mem[rule_raddr];
        end
    end

    // state stack memory, entry 0 is read as state 0
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_q <= stk_mem[stk_raddr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= SEQ_IDLE;
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            sp_reg        <= SPW'(1);
            top_reg       <= '0;
            status_reg    <= STATUS_RUN;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg    <= seq_next;
            sp_reg     <= sp_next;
            top_reg    <= top_next;
            status_reg <= status_next;
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (&clr_cnt_reg)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        reds_reg      <= reds_next;
        col_reg       <= col_next;
        col_bad_reg   <= col_bad_next;
        rule_reg      <= rule_next;
        base_zero_reg <= base_zero_next;
        sym_bad_reg   <= sym_bad_next;
        if (out_load)
        begin
            kind_reg      <= kind_next;
            rule_num_reg  <= rule_num_next;
            new_state_reg <= new_state_next;
            cause_reg     <= cause_next;
            last_reg      <= last_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign kind         = kind_reg;
    assign rule_number  = rule_num_reg;
    assign new_state    = new_state_reg;
    assign error_cause  = cause_reg;
    assign last         = last_reg;

endmodule

### rtl/lrp_checker.sv
// lrp_checker: port-level checks for the LR parse engine, bound to its top level
// depends on lrp_pkg and lr_parse_driver
module lrp_checker
    import lrp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_stall,
    input logic [2:0] kind,
    input logic [4:0] rule_number,
    input logic [5:0] new_state,
    input logic [2:0] error_cause,
    input logic       last
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(kind) &&
        $stable(rule_number) && $stable(new_state) && $stable(error_cause) && $stable(last))
        else $error("result beat changed under stall");

    // only reductions continue a token
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((kind == KIND_REDUCE) == !last))
        else $error("last flag does not match result kind");

    // a cause appears exactly on error beats
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((kind == KIND_ERROR) == (error_cause != CAUSE_NONE)))
        else $error("error cause does not match result kind");

    // beats with no rule carry rule 0
    a_rule: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_SHIFT || kind == KIND_ACCEPT ||
        kind == KIND_IGNORED) |-> rule_number == 5'd0)
        else $error("rule number set on a beat without a rule");

endmodule

bind lr_parse_driver lrp_checker u_lrp_checker (.*);

### tb/lr_parse_driver_test.sv
// lr_parse_driver_test: self-checking bench for the table-driven LR parse engine
// drives cell, rule, token and restart items and checks every result beat against
// a local model of the parser; depends on lrp_pkg and lr_parse_driver
module lr_parse_driver_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lrp_pkg::*;

    localparam int N_STATES    = 64;
    localparam int N_SYMBOLS   = 16;
    localparam int N_RULES     = 32;
    localparam int STACK_SLOTS = 32;
    localparam int REDUCE_CAP  = 63;

    // one input item, 32 bits packed
    typedef struct packed {
        logic [1:0]        op;
        logic [5:0]        state_row;
        logic [3:0]        symbol_column;
        logic signed [6:0] action_value;
        logic [4:0]        rule_index;
        logic [3:0]        rule_symbol;
        logic [3:0]        rule_length;
    } parse_item_t;

    // one result beat
    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] rule_number;
        logic [5:0] new_state;
        logic [2:0] error_cause;
        logic       last;
    } parse_beat_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    logic [1:0]        op = '0;
    logic [5:0]        state_row = '0;
    logic [3:0]        symbol_column = '0;
    logic signed [6:0] action_value = '0;
    logic [4:0]        rule_index = '0;
    logic [3:0]        rule_symbol = '0;
    logic [3:0]        rule_length = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [2:0]        kind;
    logic [4:0]        rule_number;
    logic [5:0]        new_state;
    logic [2:0]        error_cause;
    logic              last;

    // parser model state
    logic signed [6:0] action_cells [0:N_STATES*N_SYMBOLS-1];
    logic [3:0]        rule_lhs [0:N_RULES-1];
    logic [3:0]        rule_pop [0:N_RULES-1];
    logic [5:0]        state_stack [0:STACK_SLOTS-1];
    int                stack_fill;
    logic [1:0]        parse_status;

    parse_beat_t pending_beats [$];
    int          errors = 0;
    bit          sender_idle = 1'b0;
    int          idle_span = 0;

    lr_parse_driver #(
        .STATES(N_STATES),
        .SYMBOLS(N_SYMBOLS),
        .RULES(N_RULES),
        .STACK_DEPTH(STACK_SLOTS),
        .MAX_REDUCTIONS(REDUCE_CAP)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .op(op),
        .state_row(state_row),
        .symbol_column(symbol_column),
        .action_value(action_value),
        .rule_index(rule_index),
        .rule_symbol(rule_symbol),
        .rule_length(rule_length),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .kind(kind),
        .rule_number(rule_number),
        .new_state(new_state),
        .error_cause(error_cause),
        .last(last)
    );

    always #4 clk = ~clk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void queue_beat(logic [2:0] k, logic [4:0] rn, logic [5:0] st,
                                       logic [2:0] ec, logic lst);
        pending_beats.push_back('{kind: k, rule_number: rn, new_state: st,
                                  error_cause: ec, last: lst});
    endfunction

    // parser model: update tables and stack, queue the beats a token causes
    task automatic advance_parser(input parse_item_t it);
        int         act;
        int         gv;
        int         r;
        int         len;
        int         reds;
        logic [5:0] top;
        logic [5:0] base;
        logic [2:0] cause;
        bit         done;
        reds = 0;
        done = 1'b0;
        case (it.op)
            OP_WRITE_CELL:
                action_cells[it.state_row * N_SYMBOLS + it.symbol_column] = it.action_value;
            OP_WRITE_RULE:
            begin
                rule_lhs[it.rule_index] = it.rule_symbol;
                rule_pop[it.rule_index] = it.rule_length;
            end
            OP_RESTART:
            begin
                state_stack[0] = '0;
                stack_fill = 1;
                parse_status = STATUS_RUN;
            end
            OP_TOKEN:
            begin
                if (parse_status != STATUS_RUN)
                begin
                    queue_beat(KIND_IGNORED, '0, state_stack[stack_fill - 1], CAUSE_NONE, 1'b1);
                    done = 1'b1;
                end
                while (!done)
                begin
                    top = state_stack[stack_fill - 1];
                    act = action_cells[top * N_SYMBOLS + it.symbol_column];
                    cause = CAUSE_NONE;
                    r = 0;
                    if (act == 0)
                        cause = CAUSE_EMPTY_CELL;
                    else if (act == -1)
                    begin
                        parse_status = STATUS_ACC;
                        queue_beat(KIND_ACCEPT, '0, top, CAUSE_NONE, 1'b1);
                        done = 1'b1;
                    end
                    else if (act > 0)
                    begin
                        if (act >= N_STATES)
                            cause = CAUSE_BAD_GOTO;
                        else if (stack_fill >= STACK_SLOTS)
                            cause = CAUSE_OVERFLOW;
                        else
                        begin
                            state_stack[stack_fill] = 6'(act);
                            stack_fill++;
                            queue_beat(KIND_SHIFT, '0, 6'(act), CAUSE_NONE, 1'b1);
                            done = 1'b1;
                        end
                    end
                    else
                    begin
                        // reduce: pop the rule length, push the goto of the exposed state
                        r = -act - 2;
                        if (reds >= REDUCE_CAP)
                            cause = CAUSE_REDUCE_LIMIT;
                        else if (r >= N_RULES)
                            cause = CAUSE_EMPTY_CELL;
                        else
                        begin
                            len = rule_pop[r];
                            if (len >= stack_fill)
                                cause = CAUSE_UNDERFLOW;
                            else
                            begin
                                base = state_stack[stack_fill - len - 1];
                                gv = action_cells[base * N_SYMBOLS + rule_lhs[r]];
                                if (gv <= 0 || gv >= N_STATES)
                                    cause = CAUSE_BAD_GOTO;
                                else if (stack_fill - len >= STACK_SLOTS)
                                    cause = CAUSE_OVERFLOW;
                                else
                                begin
                                    stack_fill = stack_fill - len;
                                    state_stack[stack_fill] = 6'(gv);
                                    stack_fill++;
                                    queue_beat(KIND_REDUCE, 5'(r), 6'(gv), CAUSE_NONE, 1'b0);
                                    reds++;
                                end
                            end
                        end
                    end
                    // errors leave the stack alone and stop the parse
                    if (cause != CAUSE_NONE)
                    begin
                        parse_status = STATUS_ERR;
                        queue_beat(KIND_ERROR, 5'(r), top, cause, 1'b1);
                        done = 1'b1;
                    end
                end
            end
        endcase
    endtask

    // present one item, wait until it is accepted, then model it
    task automatic send_item(input parse_item_t it);
        int gap;
        if (idle_span == 0)
        begin
            sender_idle = ($urandom_range(0, 3) != 0);
            idle_span = $urandom_range(10, 40);
        end
        idle_span--;
        gap = sender_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid    <= 1'b1;
        op            <= it.op;
        state_row     <= it.state_row;
        symbol_column <= it.symbol_column;
        action_value  <= it.action_value;
        rule_index    <= it.rule_index;
        rule_symbol   <= it.rule_symbol;
        rule_length   <= it.rule_length;
        do
            @(posedge clk);
        while (item_stall);
        advance_parser(it);
    endtask

    task automatic send_cell(input logic [5:0] row, input logic [3:0] col, input int val);
        parse_item_t it;
        it = parse_item_t'($urandom);
        it.op = OP_WRITE_CELL;
        it.state_row = row;
        it.symbol_column = col;
        it.action_value = 7'(val);
        send_item(it);
    endtask

    task automatic send_rule(input logic [4:0] idx, input logic [3:0] sym,
                             input logic [3:0] len);
        parse_item_t it;
        it = parse_item_t'($urandom);
        it.op = OP_WRITE_RULE;
        it.rule_index = idx;
        it.rule_symbol = sym;
        it.rule_length = len;
        send_item(it);
    endtask

    task automatic send_token(input logic [3:0] col);
        parse_item_t it;
        it = parse_item_t'($urandom);
        it.op = OP_TOKEN;
        it.symbol_column = col;
        send_item(it);
    endtask

    task automatic send_restart();
        parse_item_t it;
        it = parse_item_t'($urandom);
        it.op = OP_RESTART;
        send_item(it);
    endtask

    // hold the sender off until every queued beat has arrived
    task automatic wait_drained();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_beats.size() != 0);
    endtask

    // mostly nonterminal columns and short rules
    function automatic parse_item_t shape_rule(parse_item_t it);
        it.op = OP_WRITE_RULE;
        if ($urandom_range(0, 4) != 0)
        begin
            it.rule_symbol = 4'($urandom_range(8, 11));
            it.rule_length = 4'($urandom_range(0, 2));
        end
        return it;
    endfunction

    // cleared table: empty cell error, then an ignored token
    task automatic test_cleared_table();
        send_token(4'd15);
        send_token(4'd0);
        send_restart();
        wait_drained();
    endtask

    // shift, bad goto, reduce and accept on a tiny grammar
    task automatic test_shift_reduce_accept();
        send_rule(5'd0, 4'd8, 4'd1);
        send_cell(6'd0, 4'd1, 5);
        send_cell(6'd5, 4'd3, -2);
        send_token(4'd1);
        send_token(4'd3);
        send_restart();
        send_cell(6'd0, 4'd8, 7);
        send_cell(6'd7, 4'd3, -1);
        send_token(4'd1);
        send_token(4'd3);
        send_restart();
        wait_drained();
    endtask

    // rule pops the only state on the stack
    task automatic test_underflow();
        send_cell(6'd0, 4'd4, -2);
        send_token(4'd4);
        send_restart();
        wait_drained();
    endtask

    // most negative cell names a rule past the table
    task automatic test_rule_out_of_range();
        send_cell(6'd0, 4'd6, -64);
        send_token(4'd6);
        send_restart();
        wait_drained();
    endtask

    // empty rule keeps pushing until the stack is full
    task automatic test_reduce_overflow();
        send_rule(5'd1, 4'd9, 4'd0);
        send_cell(6'd0, 4'd7, -3);
        send_cell(6'd0, 4'd9, 10);
        send_cell(6'd10, 4'd7, -3);
        send_cell(6'd10, 4'd9, 10);
        send_token(4'd7);
        send_restart();
        wait_drained();
    endtask

    // reduction that returns to its own state until the per-token cap
    task automatic test_reduce_limit();
        send_rule(5'd2, 4'd11, 4'd1);
        send_cell(6'd0, 4'd12, 12);
        send_cell(6'd12, 4'd13, -4);
        send_cell(6'd0, 4'd11, 12);
        send_token(4'd12);
        send_token(4'd13);
        send_restart();
        wait_drained();
    endtask

    // random grammar edits mixed with token streams in a small state region
    task automatic test_random_parse();
        parse_item_t it;
        int          pick;
        int          v;
        int          k;
        int          n;
        // every rule is defined before any random reduction can use it
        for (k = 0; k < N_RULES; k++)
        begin
            it = shape_rule(parse_item_t'($urandom));
            it.rule_index = 5'(k);
            send_item(it);
        end
        send_restart();
        for (n = 0; n < 55; n++)
        begin
            it = parse_item_t'($urandom);
            pick = $urandom_range(0, 99);
            if (parse_status != STATUS_RUN && pick < 70)
                it.op = OP_RESTART;
            else if (pick < 30)
            begin
                it.op = OP_WRITE_CELL;
                if ($urandom_range(0, 99) < 85)
                    it.state_row = 6'($urandom_range(0, 7));
                if ($urandom_range(0, 99) < 85)
                    it.symbol_column = 4'($urandom_range(0, 11));
                v = $urandom_range(0, 99);
                if (v < 45)
                    it.action_value = 7'($urandom_range(1, 7));
                else if (v < 68)
                    it.action_value = 7'(-2 - int'($urandom_range(0, 7)));
                else if (v < 76)
                    it.action_value = 7'(-1);
                else if (v < 83)
                    it.action_value = '0;
            end
            else if (pick < 38)
            begin
                it = shape_rule(it);
                if ($urandom_range(0, 3) != 0)
                    it.rule_index = 5'($urandom_range(0, 7));
            end
            else if (pick < 92)
            begin
                it.op = OP_TOKEN;
                if ($urandom_range(0, 99) < 85)
                    it.symbol_column = 4'($urandom_range(0, 7));
            end
            else
                it.op = OP_RESTART;
            send_item(it);
            if ($urandom_range(0, 29) == 0)
                wait_drained();
        end
    endtask

    // receiver stall: busy stretches with random holds, quiet stretches without
    initial
    begin : result_stall_gen
        int  hold;
        int  span;
        bit  quiet;
        hold = 0;
        span = 0;
        quiet = 1'b0;
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                quiet = ($urandom_range(0, 3) == 0);
                span = $urandom_range(20, 200);
            end
            span--;
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                hold--;
            end
            else
            begin
                result_stall <= 1'b0;
                if (!quiet && $urandom_range(0, 2) == 0)
                    hold = pick_gap();
            end
        end
    end

    // fields shown as kind/rule/state/cause/last
    task automatic note_failure(input string what, input parse_beat_t want,
                                input parse_beat_t got);
        errors++;
        if (errors <= 10)
            $display("%0t %s: expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                     $realtime, what, want.kind, want.rule_number, want.new_state,
                     want.error_cause, want.last, got.kind, got.rule_number,
                     got.new_state, got.error_cause, got.last);
    endtask

    // compare each taken result beat with the oldest queued one
    always @(posedge clk)
    begin : check_beats
        parse_beat_t got;
        parse_beat_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            got = {kind, rule_number, new_state, error_cause, last};
            if (pending_beats.size() == 0)
                note_failure("unexpected beat", '0, got);
            else
            begin
                want = pending_beats.pop_front();
                if (want != got)
                    note_failure("beat mismatch", want, got);
            end
        end
    end

    // run limit
    initial
    begin
        #15_000_000;
        $display("lr_parse_driver_test: FAIL");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < N_STATES * N_SYMBOLS; i++)
            action_cells[i] = '0;
        for (int i = 0; i < N_RULES; i++)
        begin
            rule_lhs[i] = '0;
            rule_pop[i] = '0;
        end
        for (int i = 0; i < STACK_SLOTS; i++)
            state_stack[i] = '0;
        stack_fill = 1;
        parse_status = STATUS_RUN;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_cleared_table();
        test_shift_reduce_accept();
        test_underflow();
        test_rule_out_of_range();
        test_reduce_overflow();
        test_reduce_limit();
        test_random_parse();

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_beats.size() == 0)
            $display("lr_parse_driver_test: PASS");
        else
            $display("lr_parse_driver_test: FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/lrp_pkg.sv
rtl/lr_parse_driver.sv
rtl/lrp_checker.sv
tb/lr_parse_driver_test.sv
